@@ hw/rtl/orbl_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// orbl_pkg
// Types and codes shared by the overwriting byte log ring.
// ----------------------------------------------------------------------------
package orbl_pkg;

  localparam logic [1:0] OP_PUT     = 2'd0;
  localparam logic [1:0] OP_READ    = 2'd1;
  localparam logic [1:0] OP_CLEAR   = 2'd2;
  localparam logic [1:0] OP_IGNORED = 2'd3;

  localparam logic [0:0] REG_HOLD_CLEAR = 1'd0;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] put_byte;
    logic [6:0] read_count;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_byte;
    logic       empty_flag;
    logic       last_of_burst;
  } out_item_t;

  typedef struct packed {
    logic put;
    logic clear;
    logic rd_start;
    logic fetch;
  } cmd_t;

  typedef struct packed {
    logic n_zero;
    logic rem_zero;
  } status_t;

endpackage

@@ hw/rtl/orbl_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// orbl_ctrl
// Sequencer: accepts operations, steps read bursts one byte at a time.
// ----------------------------------------------------------------------------
module orbl_ctrl
  import orbl_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [1:0] op,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  input  status_t    status,
  output cmd_t       cmd
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_FETCH = 2'd1;
  localparam logic [1:0] S_SHOW  = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       accept;

  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_SHOW);
  assign accept    = in_valid && (state == S_IDLE);

  assign cmd.put      = accept && (op == OP_PUT);
  assign cmd.clear    = accept && (op == OP_CLEAR);
  assign cmd.rd_start = accept && (op == OP_READ);
  assign cmd.fetch    = (state == S_FETCH);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cmd.rd_start) begin
          state_next = status.n_zero ? S_SHOW : S_FETCH;
        end
      end
      S_FETCH: state_next = S_SHOW;
      S_SHOW: begin
        if (!out_stall) begin
          state_next = status.rem_zero ? S_IDLE : S_FETCH;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ hw/rtl/orbl_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// orbl_dp
// Ring storage, pointers, fill level, burst counter and output register.
// ----------------------------------------------------------------------------
module orbl_dp
  import orbl_pkg::*;
#(
  parameter int DEPTH     = 4096,
  parameter int MAX_BURST = 64
) (
  input  logic      clk,
  input  logic      rst,
  input  cmd_t      cmd,
  input  logic      hold_clear,
  input  in_item_t  in_data,
  output status_t   status,
  output out_item_t out_data
);

  localparam int IW = $clog2(DEPTH);
  localparam int FW = $clog2(DEPTH + 1);
  localparam int CW = $clog2(MAX_BURST + 1);
  localparam int MW = (FW > 7) ? FW : 7;

  logic [7:0]    mem [DEPTH];
  logic [7:0]    rdata;
  logic [IW-1:0] widx;
  logic [IW-1:0] ridx;
  logic [IW-1:0] widx_next;
  logic [IW-1:0] ridx_next;
  logic [FW-1:0] fill;
  logic [CW-1:0] remaining;
  logic          empty;
  logic [CW-1:0] capped;
  logic [CW-1:0] n;

  assign widx_next = (widx == IW'(DEPTH - 1)) ? '0 : widx + 1'b1;
  assign ridx_next = (ridx == IW'(DEPTH - 1)) ? '0 : ridx + 1'b1;

  assign capped = (in_data.read_count > 7'(MAX_BURST)) ? CW'(MAX_BURST)
                                                       : in_data.read_count[CW-1:0];
  assign n = (MW'(capped) > MW'(fill)) ? CW'(MW'(fill)) : capped;

  assign status.n_zero   = (n == '0);
  assign status.rem_zero = (remaining == '0);

  assign out_data.read_byte     = empty ? 8'h00 : rdata;
  assign out_data.empty_flag    = empty;
  assign out_data.last_of_burst = empty || (remaining == '0);

  always_ff @(posedge clk) begin
    if (cmd.put) begin
      mem[widx] <= in_data.put_byte;
    end
    if (cmd.fetch) begin
      rdata <= mem[ridx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      widx      <= '0;
      ridx      <= '0;
      fill      <= '0;
      remaining <= '0;
      empty     <= 1'b0;
    end else begin
      if (cmd.put) begin
        widx <= widx_next;
        if (fill == FW'(DEPTH)) begin
          ridx <= widx_next;
        end else begin
          fill <= fill + 1'b1;
        end
      end
      if (cmd.clear && !hold_clear) begin
        ridx <= widx;
        fill <= '0;
      end
      if (cmd.rd_start) begin
        remaining <= n;
        empty     <= status.n_zero;
      end
      if (cmd.fetch) begin
        ridx      <= ridx_next;
        fill      <= fill - 1'b1;
        remaining <= remaining - 1'b1;
      end
    end
  end

endmodule

@@ hw/rtl/overwrite_ring_byte_log.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// overwrite_ring_byte_log
// Byte log ring of DEPTH entries that overwrites its oldest byte when full.
//
// Input channel (in_valid / in_stall / in_data) carries put, read and clear
// operations. A put or clear never stalls the input. A read of n bytes gives n
// results on the output channel (out_valid / out_stall / out_data), the last
// one marked; n is the request capped at MAX_BURST and at the fill level.
// A read that finds nothing gives a single result with empty_flag set.
// Each byte passes through FETCH, which reads the ring memory into the output
// register, then SHOW; a byte is fetched only after the one before is taken.
// An empty result shows in the cycle after its transfer. The input is stalled
// from the transfer of a read until its last result has been taken.
// A stalled result holds in the output register until taken.
// Reset clears pointers, fill level and hold_clear; ring contents are kept
// and never read before written. hold_clear (APB, address 0) blocks clears.
// ----------------------------------------------------------------------------
module overwrite_ring_byte_log
  import orbl_pkg::*;
#(
  parameter int DEPTH     = 4096,
  parameter int MAX_BURST = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic    hold_clear;
  cmd_t    cmd;
  status_t status;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_HOLD_CLEAR) ? {31'd0, hold_clear} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_clear <= 1'b0;
    end else if (psel && penable && pwrite && (paddr[2] == REG_HOLD_CLEAR)) begin
      hold_clear <= pwdata[0];
    end
  end

  orbl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .op        (in_data.op),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  orbl_dp #(
    .DEPTH     (DEPTH),
    .MAX_BURST (MAX_BURST)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .hold_clear (hold_clear),
    .in_data    (in_data),
    .status     (status),
    .out_data   (out_data)
  );

endmodule

@@ hw/rtl/orbl_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// orbl_checker
// Port-level checks for the byte log ring, bound to the top level.
// ----------------------------------------------------------------------------
module orbl_checker
  import orbl_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_stall,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_busy_on_result: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input open while result pending");

  a_read_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (in_data.op == OP_READ) |=> in_stall)
    else $error("read transfer did not occupy block");

  a_put_one_cycle: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (in_data.op == OP_PUT) |=> !in_stall && !out_valid)
    else $error("put did not complete in one cycle");

  a_empty_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.empty_flag |-> out_data.last_of_burst &&
      (out_data.read_byte == 8'h00))
    else $error("empty result malformed");

endmodule

bind overwrite_ring_byte_log orbl_checker u_orbl_checker (.*);
